FILE: rtl/core/jss_pkg.sv
`timescale 1ns / 1ps
package jss_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int LEN_RESET       = 1024;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// word index of the table_length register on the APB port
	localparam logic REG_TABLE_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_JUMP,
		S_SCAN
	} srch_state_t;

	// result of one search, as handed from the search unit to the top
	typedef struct packed {
		logic done;
		logic hit;
	} srch_stat_t;

endpackage

FILE: rtl/core/jss_mem.sv
`timescale 1ns / 1ps
module jss_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/jss_isqrt.sv
`timescale 1ns / 1ps
module jss_isqrt #(
	parameter int LEN_W = 11,
	parameter int R_W   = (LEN_W + 1) / 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [LEN_W-1:0] n,
	output logic             busy,
	output logic [R_W-1:0]   root
);

	localparam int BW = (R_W > 1) ? $clog2(R_W) : 1;

	logic             run_q;
	logic [BW-1:0]    b_q;
	logic [R_W-1:0]   r_q;
	logic [LEN_W-1:0] n_q;
	logic [R_W-1:0]   trial;
	logic [2*R_W-1:0] sq;
	logic             fits;

	// settle one root bit per cycle, top bit first
	always_comb begin
		trial = r_q | (R_W'(1) << b_q);
		sq    = (2*R_W)'(trial) * (2*R_W)'(trial);
		fits  = sq <= (2*R_W)'(n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (go) begin
			run_q <= 1'b1;
		end else if (run_q && b_q == '0) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			r_q <= '0;
			n_q <= n;
			b_q <= BW'(R_W - 1);
		end else if (run_q) begin
			if (fits) begin
				r_q <= trial;
			end
			b_q <= b_q - 1'b1;
		end
	end

	assign busy = run_q;
	assign root = r_q;

endmodule

FILE: rtl/core/jss_search.sv
`timescale 1ns / 1ps
module jss_search
	import jss_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH),
	parameter int LEN_W = AW + 1,
	parameter int R_W   = (LEN_W + 1) / 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] key,
	input  logic [LEN_W-1:0] len,
	input  logic [R_W-1:0]   root,
	output logic             re,
	output logic [AW-1:0]    raddr,
	input  logic [WIDTH-1:0] rdata,
	output logic             busy,
	output srch_stat_t       stat,
	output logic [AW-1:0]    position
);

	localparam int HW = LEN_W + 1;

	srch_state_t      state_q, state_d;
	logic [WIDTH-1:0] key_q;
	logic [HW-1:0]    lo_q, hi_q, lim_q;
	logic             done_q, hit_q;
	logic [AW-1:0]    pos_q;

	logic          less, empty, passed, at_lim;
	logic [HW-1:0] len_x, m_x, hi_nx, jump_end, lim_nx, lo_inc, addr;
	logic          fin, hit;

	always_comb begin
		less     = $signed(rdata) < $signed(key_q);
		len_x    = HW'(len);
		m_x      = HW'(root);
		empty    = len == '0;
		hi_nx    = hi_q + m_x;
		jump_end = (hi_nx < len_x) ? hi_nx : len_x;
		lim_nx   = (hi_q < len_x) ? hi_q : len_x;
		passed   = hi_q >= len_x;
		lo_inc   = lo_q + 1'b1;
		at_lim   = lo_inc == lim_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (go && !empty) begin
					state_d = S_JUMP;
				end
			end
			S_JUMP: begin
				if (!less) begin
					state_d = S_SCAN;
				end else if (passed) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!less || at_lim) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		re   = 1'b0;
		addr = '0;
		fin  = 1'b0;
		hit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				// first block ends at m-1; m never exceeds the length
				re   = go && !empty;
				addr = m_x - 1'b1;
				fin  = go && empty;
			end
			S_JUMP: begin
				if (!less) begin
					re   = 1'b1;
					addr = lo_q;
				end else if (passed) begin
					fin = 1'b1;
				end else begin
					re   = 1'b1;
					addr = jump_end - 1'b1;
				end
			end
			S_SCAN: begin
				if (!less) begin
					fin = 1'b1;
					hit = rdata == key_q;
				end else if (at_lim) begin
					fin = 1'b1;
				end else begin
					re   = 1'b1;
					addr = lo_inc;
				end
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit;
		pos_q <= hit ? AW'(lo_q) : '0;
		case (state_q)
			S_IDLE: begin
				key_q <= key;
				lo_q  <= '0;
				hi_q  <= m_x;
			end
			S_JUMP: begin
				if (less) begin
					lo_q <= hi_q;
					hi_q <= hi_nx;
				end else begin
					lim_q <= lim_nx;
				end
			end
			S_SCAN: begin
				if (less) begin
					lo_q <= lo_inc;
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign raddr     = AW'(addr);
	assign busy      = state_q != S_IDLE;
	assign stat.done = done_q;
	assign stat.hit  = hit_q;
	assign position  = pos_q;

endmodule

FILE: rtl/core/jump_search_sorted_table_top.sv
`timescale 1ns / 1ps
// Jump search over an ascending table of signed words.
// Command channel: present opcode and its fields with start; the word is
// taken at a clock edge where start is high and busy is low. A load writes
// entry_value at entry_index (indexes past the depth are dropped) and gives
// no result. A search returns one result word: done pulses for exactly one
// cycle with found and position; the receiver cannot hold it off. position
// is 0 on a miss.
// A search makes one read of the table memory per step: block reads (up to
// about sqrt(length)), then a scan of the entries of the last block (up to
// sqrt(length)). At a length of 1024 that is up to 32 block reads and a
// 32-entry scan. An empty table answers not found on the cycle after accept.
// table_length is written over APB at address 0; the user must write it only
// while idle, as the block itself does not enforce it. The jump size
// floor(sqrt(length)) is then found by a bit-serial root unit, one bit per
// cycle; busy stays high from the cycle after the write until the root
// settles. The same pass runs right after reset. Table contents are undefined
// after reset until loaded.
module jump_search_sorted_table_top
	import jss_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   opcode,
	input  logic [AW-1:0]          entry_index,
	input  logic [VALUE_WIDTH-1:0] entry_value,
	input  logic [VALUE_WIDTH-1:0] search_key,
	output logic                   done,
	output logic                   found,
	output logic [AW-1:0]          position,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int LEN_W = AW + 1;
	localparam int R_W   = (LEN_W + 1) / 2;

	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       len_eff;
	logic                   root_go_q;
	logic                   root_busy;
	logic [R_W-1:0]         root;
	logic                   srch_busy;
	srch_stat_t             stat;
	logic                   take, cfg_wr;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == REG_TABLE_LENGTH;
	assign prdata = (paddr[2] == REG_TABLE_LENGTH) ? 32'(len_q) : '0;

	// clamp the length to the table depth
	assign len_eff = (len_q > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_W'(LEN_RESET);
			root_go_q <= 1'b1;
		end else begin
			if (cfg_wr) begin
				len_q <= pwdata[LEN_W-1:0];
			end
			root_go_q <= cfg_wr;
		end
	end

	assign busy   = srch_busy || root_busy || root_go_q;
	assign take   = start && !busy;
	assign mem_we = take && opcode == OP_LOAD && 32'(entry_index) < 32'(TABLE_DEPTH);

	jss_isqrt #(
		.LEN_W(LEN_W),
		.R_W  (R_W)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (root_go_q),
		.n     (len_eff),
		.busy  (root_busy),
		.root  (root)
	);

	jss_mem #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(VALUE_WIDTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(entry_index),
		.wdata(entry_value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	jss_search #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(VALUE_WIDTH),
		.AW   (AW),
		.LEN_W(LEN_W),
		.R_W  (R_W)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (take && opcode == OP_SEARCH),
		.key     (search_key),
		.len     (len_eff),
		.root    (root),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata   (mem_rdata),
		.busy    (srch_busy),
		.stat    (stat),
		.position(position)
	);

	assign done  = stat.done;
	assign found = stat.hit;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !srch_busy)
		else $error("result strobe while search still running");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (LEN_W'(position) < len_eff))
		else $error("hit position beyond table length");

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && opcode == OP_SEARCH && len_eff != '0) |=> srch_busy)
		else $error("accepted search did not start");

	a_empty_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(take && opcode == OP_SEARCH && len_eff == '0) |=> (done && !found))
		else $error("empty table search did not answer at once");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
	import jss_pkg::*;

	localparam int     ITEM_BUDGET = 1120;
	localparam int     QUIET_TAIL  = 50;
	localparam int     STALL_LIMIT = 1000;
	localparam int     SETTLE      = 80;
	localparam longint VAL_MIN     = -64'sd2147483648;
	localparam longint VAL_MAX     = 64'sd2147483647;

	class lookup_tracker;
		int          tbl [TABLE_DEPTH_DEF];
		logic [10:0] tbl_len = 11'(LEN_RESET);
		bit          exp_found [$];
		logic [9:0]  exp_pos [$];
		int          err_count = 0;

		function void set_length(logic [10:0] v);
			tbl_len = v;
		endfunction

		// jump through blocks of floor(sqrt(n)), then scan the last block
		function bit jump_lookup(int key, output logic [9:0] where);
			int n, m, hi, lo, lim;
			where = '0;
			n = (tbl_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(tbl_len);
			if (n == 0)
				return 1'b0;
			m = 0;
			while ((m + 1) * (m + 1) <= n)
				m++;
			hi = m;
			lo = 0;
			while (tbl[((hi < n) ? hi : n) - 1] < key) begin
				lo = hi;
				hi += m;
				if (lo >= n)
					return 1'b0;
			end
			lim = (hi < n) ? hi : n;
			while (tbl[lo] < key) begin
				lo++;
				if (lo == lim)
					return 1'b0;
			end
			if (tbl[lo] == key) begin
				where = 10'(lo);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_word(logic op, logic [9:0] idx, int val, int key);
			logic [9:0] where;
			bit         hit;
			if (op == OP_LOAD) begin
				tbl[idx] = val;
			end else begin
				hit = jump_lookup(key, where);
				exp_found.push_back(hit);
				exp_pos.push_back(where);
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			err_count++;
		endtask

		task check_result(logic f, logic [9:0] p);
			bit         ef;
			logic [9:0] ep;
			if (exp_found.size() == 0) begin
				report($sformatf("word found=%0b position=%0d with none pending", f, p));
				return;
			end
			ef = exp_found.pop_front();
			ep = exp_pos.pop_front();
			if (f !== ef)
				report($sformatf("found %0b, predicted %0b", f, ef));
			if (p !== ep)
				report($sformatf("position %0d, predicted %0d", p, ep));
		endtask

		function int pending();
			return exp_found.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        opcode = OP_LOAD;
	logic [9:0]  entry_index = '0;
	logic [31:0] entry_value = '0;
	logic [31:0] search_key = '0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        busy;
	logic        done;
	logic        found;
	logic [9:0]  position;
	logic [31:0] prdata;
	logic        pready;

	lookup_tracker sb;
	int            items = 0;
	int            progress = 0;
	int            seen_progress = 0;
	int            stall_cycles = 0;
	bit            idling = 1'b0;

	jump_search_sorted_table_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.search_key (search_key),
		.done       (done),
		.found      (found),
		.position   (position),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			sb.check_result(found, position);
			progress++;
		end
	end

	always @(posedge clk) begin
		if (progress != seen_progress) begin
			seen_progress = progress;
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold the word until the block takes it
	task automatic send_word(logic op, logic [9:0] idx, int val, int key);
		start <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		entry_value <= val;
		search_key <= key;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_word(op, idx, val, key);
		items++;
		progress++;
	endtask

	task automatic load_entry(logic [9:0] idx, int val);
		send_word(OP_LOAD, idx, val, $urandom);
	endtask

	task automatic seek(int key);
		send_word(OP_SEARCH, 10'($urandom_range(0, 1023)), $urandom, key);
	endtask

	task automatic gap();
		if (idling && $urandom_range(0, 3) == 0)
			pause($urandom_range(1, 7));
	endtask

	// drain all searches, let the last load settle, then write over APB
	task automatic write_length(logic [10:0] v);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TABLE_LENGTH, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_length(v);
		progress++;
	endtask

	// load count non-decreasing words from lo_v to at most hi_v
	task automatic load_ascending(int count, longint lo_v, longint hi_v);
		longint stepmax, cur;
		stepmax = (hi_v - lo_v) / count;
		if ($urandom_range(0, 3) == 0 && stepmax > 3)
			stepmax = 3;
		cur = lo_v + longint'($urandom_range(0, 32'(stepmax)));
		for (int i = 0; i < count; i++) begin
			load_entry(10'(i), int'(cur));
			gap();
			cur += longint'($urandom_range(0, 32'(stepmax)));
		end
	endtask

	initial begin
		int len, n_eff, key, pick;
		sb = new;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_length(11'd4);
		load_entry(10'd0, int'(VAL_MIN));
		load_entry(10'd1, -1);
		load_entry(10'd2, 0);
		load_entry(10'd3, int'(VAL_MAX));
		seek(int'(VAL_MIN));
		seek(int'(VAL_MAX));
		seek(-1);
		seek(0);
		seek(-7);
		seek(9);
		seek(int'(VAL_MAX - 1));
		// break the order and search anyway
		load_entry(10'd1, 100);
		seek(0);
		seek(100);
		write_length(11'd1);
		seek(int'(VAL_MIN));
		seek(5);
		write_length(11'd0);
		seek(0);

		write_length(11'(LEN_RESET));
		idling = 1'b1;
		load_ascending(TABLE_DEPTH_DEF, VAL_MIN, VAL_MAX);

		while (items < ITEM_BUDGET) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				len = 0;
			else if (pick == 1)
				len = 1;
			else if (pick == 2)
				len = LEN_RESET;
			else if (pick == 3)
				len = 2047;
			else if (pick == 4)
				len = $urandom_range(1025, 2047);
			else if (pick <= 6)
				len = $urandom_range(65, 1023);
			else
				len = $urandom_range(2, 64);
			write_length(11'(len));
			idling = (items < ITEM_BUDGET - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
			n_eff = (len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : len;
			// reload the head below the next entry so the order holds
			if (n_eff >= 1 && n_eff <= 64 && $urandom_range(0, 1) == 1)
				load_ascending(n_eff, VAL_MIN, longint'(sb.tbl[n_eff]));
			repeat ($urandom_range(6, 24)) begin
				if ($urandom_range(0, 15) == 0) begin
					load_entry(10'($urandom_range(0, 1023)), $urandom);
				end else begin
					key = $urandom;
					pick = $urandom_range(0, 9);
					if (n_eff > 0 && pick <= 6) begin
						key = sb.tbl[$urandom_range(0, n_eff - 1)];
						if (pick == 5)
							key = key + 1;
						else if (pick == 6)
							key = key - 1;
					end else if (pick == 7) begin
						key = ($urandom_range(0, 1) == 1) ? int'(VAL_MIN) : int'(VAL_MAX);
					end
					seek(key);
				end
				gap();
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.err_count == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
